FILE: src/otrb_pkg.sv
// ----------------------------------------------------------------------------
// otrb_pkg
// Shared types, constants and the truncation marker for the trace ring buffer.
// ----------------------------------------------------------------------------
package otrb_pkg;

    localparam int LOG_DEPTH = 4096;
    localparam int PTR_W     = $clog2(LOG_DEPTH);
    localparam int FILL_W    = 13;
    localparam int CAP_W     = 16;
    localparam int LEN_W     = 16;
    localparam int CALC_W    = 18;
    localparam int MARK_IDX_W = 4;

    localparam logic [CALC_W-1:0] MARK_LEN = CALC_W'(16);
    localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(4096);

    localparam int PADDR_W = 3;
    localparam logic PADDR_IDX_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_READ   = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LAYOUT,
        ST_ADDR,
        ST_DATA,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic layout;
        logic addr;
        logic data;
    } cmd_t;

    function automatic logic [7:0] mark_char(input logic [MARK_IDX_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h2E;
            4'd1:    c = 8'h2E;
            4'd2:    c = 8'h2E;
            4'd3:    c = 8'h20;
            4'd4:    c = 8'h28;
            4'd5:    c = 8'h74;
            4'd6:    c = 8'h72;
            4'd7:    c = 8'h75;
            4'd8:    c = 8'h6E;
            4'd9:    c = 8'h63;
            4'd10:   c = 8'h61;
            4'd11:   c = 8'h74;
            4'd12:   c = 8'h65;
            4'd13:   c = 8'h64;
            4'd14:   c = 8'h29;
            4'd15:   c = 8'h0A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: src/otrb_ctrl.sv
// ----------------------------------------------------------------------------
// otrb_ctrl
// Sequencer that steps one request through update, layout, address and data.
// ----------------------------------------------------------------------------
module otrb_ctrl
    import otrb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:   state_next = ST_LAYOUT;
            ST_LAYOUT: state_next = ST_ADDR;
            ST_ADDR:   state_next = ST_DATA;
            ST_DATA:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_EXEC:   cmd.exec   = 1'b1;
            ST_LAYOUT: cmd.layout = 1'b1;
            ST_ADDR:   cmd.addr   = 1'b1;
            ST_DATA:   cmd.data   = 1'b1;
            ST_OUT:    out_valid  = 1'b1;
            default:   cmd        = '0;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("input and output handshakes open together");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_EXEC)
        else $error("accepted request did not start execution");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DATA |=> out_valid)
        else $error("result not presented after data stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.exec, cmd.layout, cmd.addr, cmd.data}))
        else $error("more than one datapath command active");

endmodule

FILE: src/otrb_dp.sv
// ----------------------------------------------------------------------------
// otrb_dp
// Ring storage, pointers, snapshot layout, read addressing and config register.
// ----------------------------------------------------------------------------
module otrb_dp
    import otrb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  logic [1:0]         in_mode,
    input  logic [7:0]         in_data_byte,
    input  logic [15:0]        in_read_position,
    output logic [7:0]         out_byte,
    output logic [LEN_W-1:0]   snapshot_length,
    output logic [FILL_W-1:0]  fill_level,
    output logic [31:0]        bytes_total,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [7:0] mem [LOG_DEPTH];

    mode_t             mode_reg;
    logic [7:0]        data_reg;
    logic [15:0]       pos_reg;

    logic [PTR_W-1:0]  ptr_reg;
    logic [PTR_W-1:0]  ptr_next;
    logic              wrapped_reg;
    logic              wrapped_next;
    logic [31:0]       total_reg;
    logic [31:0]       total_next;
    logic [CAP_W-1:0]  cap_reg;

    logic [CALC_W-1:0] len_reg;
    logic [CALC_W-1:0] len_next;
    logic              mark_reg;
    logic              mark_next;
    logic [CALC_W-1:0] skip_reg;
    logic [CALC_W-1:0] skip_next;

    logic              zero_sel_reg;
    logic              mark_sel_reg;
    logic [7:0]        mark_byte_reg;
    logic [7:0]        rd_data_reg;
    logic [7:0]        out_byte_reg;

    logic [CALC_W-1:0] fill_ext;
    logic [CALC_W-1:0] cap_ext;
    logic [CALC_W-1:0] room;
    logic [CALC_W-1:0] pos_ext;
    logic [CALC_W-1:0] start_ext;
    logic [CALC_W-1:0] idx_sum;
    logic [PTR_W-1:0]  rd_addr;
    logic [FILL_W:0]   fill_wide;
    logic              cfg_wr;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[PADDR_W-1] == PADDR_IDX_CAPACITY) ? {16'b0, cap_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr && paddr[PADDR_W-1] == PADDR_IDX_CAPACITY)
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // request capture
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode_t'(in_mode);
            data_reg <= in_data_byte;
            pos_reg  <= in_read_position;
        end
    end

    // ------------------------------------------------------------------
    // ring state update
    // ------------------------------------------------------------------
    always_comb
    begin
        ptr_next     = ptr_reg;
        wrapped_next = wrapped_reg;
        total_next   = total_reg;
        case (mode_reg)
            MODE_APPEND:
            begin
                ptr_next   = ptr_reg + PTR_W'(1);
                total_next = total_reg + 32'd1;
                if (ptr_reg == PTR_W'(LOG_DEPTH - 1))
                begin
                    wrapped_next = 1'b1;
                end
            end
            MODE_CLEAR:
            begin
                ptr_next     = '0;
                wrapped_next = 1'b0;
            end
            default:
            begin
                ptr_next = ptr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            wrapped_reg <= 1'b0;
            total_reg   <= '0;
        end
        else if (cmd.exec)
        begin
            ptr_reg     <= ptr_next;
            wrapped_reg <= wrapped_next;
            total_reg   <= total_next;
        end
    end

    // ------------------------------------------------------------------
    // snapshot layout
    // ------------------------------------------------------------------
    assign fill_wide = wrapped_reg ? (FILL_W + 1)'(LOG_DEPTH) : (FILL_W + 1)'(ptr_reg);
    assign fill_ext  = CALC_W'(fill_wide);
    assign cap_ext   = CALC_W'(cap_reg);
    assign room      = cap_ext - CALC_W'(1);

    always_comb
    begin
        len_next  = '0;
        mark_next = 1'b0;
        skip_next = '0;
        if (cap_ext != '0 && fill_ext != '0)
        begin
            if (fill_ext > room)
            begin
                len_next = room;
                if (cap_ext > MARK_LEN + CALC_W'(1))
                begin
                    mark_next = 1'b1;
                    skip_next = fill_ext - (room - MARK_LEN);
                end
                else
                begin
                    skip_next = fill_ext - room;
                end
            end
            else
            begin
                len_next = fill_ext;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.layout)
        begin
            len_reg  <= len_next;
            mark_reg <= mark_next;
            skip_reg <= skip_next;
        end
    end

    // ------------------------------------------------------------------
    // read addressing and memory
    // ------------------------------------------------------------------
    assign pos_ext   = CALC_W'(pos_reg);
    assign start_ext = wrapped_reg ? CALC_W'(ptr_reg) : '0;
    assign idx_sum   = start_ext + skip_reg + pos_ext - (mark_reg ? MARK_LEN : '0);
    assign rd_addr   = idx_sum[PTR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.exec && mode_reg == MODE_APPEND)
        begin
            mem[ptr_reg] <= data_reg;
        end
        if (cmd.addr)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.addr)
        begin
            zero_sel_reg  <= (mode_reg != MODE_READ) || (pos_ext >= len_reg);
            mark_sel_reg  <= mark_reg && (pos_ext < MARK_LEN);
            mark_byte_reg <= mark_char(pos_reg[MARK_IDX_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.data)
        begin
            if (zero_sel_reg)
            begin
                out_byte_reg <= 8'h00;
            end
            else if (mark_sel_reg)
            begin
                out_byte_reg <= mark_byte_reg;
            end
            else
            begin
                out_byte_reg <= rd_data_reg;
            end
        end
    end

    assign out_byte        = out_byte_reg;
    assign snapshot_length = len_reg[LEN_W-1:0];
    assign fill_level      = fill_wide[FILL_W-1:0];
    assign bytes_total     = total_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && mode_reg == MODE_CLEAR |=> ptr_reg == '0 && !wrapped_reg)
        else $error("clear did not reset pointer and wrap flag");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && mode_reg == MODE_APPEND |=> total_reg == $past(total_reg) + 32'd1)
        else $error("append did not advance the total");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && mode_reg == MODE_READ |=> $stable(ptr_reg) && $stable(wrapped_reg))
        else $error("read changed the ring pointer");

endmodule

FILE: src/overwriting_trace_ring_buffer_unit.sv
// ----------------------------------------------------------------------------
// overwriting_trace_ring_buffer_unit
// Byte trace ring that overwrites its oldest data, with an oldest-first
// snapshot reader and an APB register for the snapshot capacity.
// ----------------------------------------------------------------------------
// Sequencing: the update, layout, address and registered memory read steps
//   run in sequence before the result is presented; the result is held until
//   taken, and a new request is accepted only after that, while idle.
// Reset: pointer, wrap flag, total and sequencer clear at once; capacity
//   returns to 4096; ring memory is not cleared and needs no clearing pass.
module overwriting_trace_ring_buffer_unit
    import otrb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [31:0]        s_axis_tdata,  // mode[1:0], data_byte[9:2], read_position[25:10]
    input  logic               s_axis_tlast,  // chunk_end
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [71:0]        m_axis_tdata,  // out_byte[7:0], snapshot_length[23:8],
                                              // fill_level[36:24], bytes_total[68:37]
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cmd_t              cmd;
    logic [7:0]        out_byte;
    logic [LEN_W-1:0]  snapshot_length;
    logic [FILL_W-1:0] fill_level;
    logic [31:0]       bytes_total;
    logic              chunk_end_unused;

    assign chunk_end_unused = s_axis_tlast;

    otrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    otrb_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .in_mode          (s_axis_tdata[1:0]),
        .in_data_byte     (s_axis_tdata[9:2]),
        .in_read_position (s_axis_tdata[25:10]),
        .out_byte         (out_byte),
        .snapshot_length  (snapshot_length),
        .fill_level       (fill_level),
        .bytes_total      (bytes_total),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    assign m_axis_tdata = {3'b000, bytes_total, fill_level, snapshot_length, out_byte};

endmodule
